// ===== rtl/window_stats_monitor_macros.svh =====
// ----------------------------------------------------------------------------
// window_stats_monitor_macros
// assertion macros used by the window statistics monitor datapath
// ----------------------------------------------------------------------------
`ifndef WINDOW_STATS_MONITOR_MACROS_SVH
`define WINDOW_STATS_MONITOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define WSM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wsm_pkg.sv =====
// ----------------------------------------------------------------------------
// wsm_pkg
// constants, control word format and microcode table of the window monitor
// ----------------------------------------------------------------------------
package wsm_pkg;

    localparam int HISTORY_DEPTH = 128;
    localparam int DATA_W        = 32;
    localparam int FILLED_W      = 8;
    localparam int PTR_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W         = DATA_W + CNT_W;
    localparam int DIV_STEPS     = (SUM_W + 1) / 2;
    localparam int DIV_W         = 2 * DIV_STEPS;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int PROD_W        = 48;
    localparam int EMA_SHIFT     = 16;
    localparam int EMA_WEIGHT    = 6554;
    localparam int EMA_ROUND     = 32768;
    localparam int STEP_W        = 3;

    localparam logic [DATA_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_UPDATE,
        OP_EMA,
        OP_PRIME,
        OP_SCAN,
        OP_DIV,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_EMPTY,
        C_SCAN_MORE,
        C_DIV_BUSY,
        C_OUT_BUSY
    } cond_t;

    localparam logic [STEP_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] ST_UPDATE = 3'd1;
    localparam logic [STEP_W-1:0] ST_EMA    = 3'd2;
    localparam logic [STEP_W-1:0] ST_PRIME  = 3'd3;
    localparam logic [STEP_W-1:0] ST_SCAN   = 3'd4;
    localparam logic [STEP_W-1:0] ST_DIV    = 3'd5;
    localparam logic [STEP_W-1:0] ST_WAIT   = 3'd6;
    localparam logic [STEP_W-1:0] ST_EMIT   = 3'd7;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic no_input;
        logic empty;
        logic scan_more;
        logic div_busy;
        logic out_busy;
    } status_t;

    // microprogram, step counter wraps from the last step back to idle
    function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        unique case (step)
            ST_IDLE:   w = '{op: OP_ACCEPT, cond: C_NO_INPUT,  target: ST_IDLE};
            ST_UPDATE: w = '{op: OP_UPDATE, cond: C_NEVER,     target: ST_IDLE};
            ST_EMA:    w = '{op: OP_EMA,    cond: C_EMPTY,     target: ST_EMIT};
            ST_PRIME:  w = '{op: OP_PRIME,  cond: C_NEVER,     target: ST_IDLE};
            ST_SCAN:   w = '{op: OP_SCAN,   cond: C_SCAN_MORE, target: ST_SCAN};
            ST_DIV:    w = '{op: OP_DIV,    cond: C_NEVER,     target: ST_IDLE};
            ST_WAIT:   w = '{op: OP_NONE,   cond: C_DIV_BUSY,  target: ST_WAIT};
            ST_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY,  target: ST_EMIT};
            default:   w = '{op: OP_NONE,   cond: C_ALWAYS,    target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/wsm_seq.sv =====
// ----------------------------------------------------------------------------
// wsm_seq
// step counter and microcode lookup with conditional jumps
// ----------------------------------------------------------------------------
module wsm_seq
    import wsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              jump;

    assign ctrl = ucode_rom(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            C_NEVER:     jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_NO_INPUT:  jump = status.no_input;
            C_EMPTY:     jump = status.empty;
            C_SCAN_MORE: jump = status.scan_more;
            C_DIV_BUSY:  jump = status.div_busy;
            C_OUT_BUSY:  jump = status.out_busy;
            default:     jump = 1'b0;
        endcase
    end

    always_comb
    begin
        if (jump)
        begin
            step_next = ctrl.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/wsm_div.sv =====
// ----------------------------------------------------------------------------
// wsm_div
// signed by unsigned divider, truncating, two quotient bits per cycle
// ----------------------------------------------------------------------------
module wsm_div
    import wsm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [SUM_W-1:0]  dividend,
    input  logic        [CNT_W-1:0]  divisor,
    output logic                     busy,
    output logic signed [DATA_W-1:0] quotient
);

    logic [DIV_W-1:0]     work_reg;
    logic [DIV_W-1:0]     work_next;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     rem_next;
    logic [CNT_W-1:0]     dsr_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic [SUM_W-1:0]     mag;
    logic [CNT_W:0]       part_hi;
    logic [CNT_W-1:0]     rem_mid;
    logic [CNT_W:0]       part_lo;
    logic                 q_hi;
    logic                 q_lo;
    logic [DATA_W-1:0]    q_mag;

    // two's complement negate, min value stays correct as unsigned
    assign mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

    always_comb
    begin
        part_hi = {rem_reg, work_reg[DIV_W-1]};
        q_hi    = (part_hi >= {1'b0, dsr_reg});
        rem_mid = q_hi ? CNT_W'(part_hi - {1'b0, dsr_reg}) : CNT_W'(part_hi);
        part_lo = {rem_mid, work_reg[DIV_W-2]};
        q_lo    = (part_lo >= {1'b0, dsr_reg});
        rem_next  = q_lo ? CNT_W'(part_lo - {1'b0, dsr_reg}) : CNT_W'(part_lo);
        work_next = {work_reg[DIV_W-3:0], q_hi, q_lo};
        cnt_next  = cnt_reg - 1'b1;
        busy_next = (cnt_reg != DIV_CNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= DIV_W'(mag);
            rem_reg  <= '0;
            dsr_reg  <= divisor;
            neg_reg  <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign q_mag    = work_reg[DATA_W-1:0];
    assign quotient = neg_reg ? -$signed(q_mag) : $signed(q_mag);
    assign busy     = busy_reg;

endmodule

// ===== rtl/wsm_datapath.sv =====
// ----------------------------------------------------------------------------
// wsm_datapath
// sample ring, counters, moving average, window scan and result register
// ----------------------------------------------------------------------------
module wsm_datapath
    import wsm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctrl_t                      ctrl,
    output status_t                    status,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [DATA_W-1:0]   sample,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [DATA_W-1:0]   latest,
    output logic signed [DATA_W-1:0]   smoothed,
    output logic signed [DATA_W-1:0]   window_mean,
    output logic signed [DATA_W-1:0]   window_min,
    output logic signed [DATA_W-1:0]   window_max,
    output logic        [FILLED_W-1:0] filled,
    output logic        [DATA_W-1:0]   total_seen,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data,
    output logic                       div_start,
    output logic signed [SUM_W-1:0]    div_dividend,
    output logic        [CNT_W-1:0]    div_divisor,
    input  logic                       div_busy,
    input  logic signed [DATA_W-1:0]   div_quotient
);

    `include "window_stats_monitor_macros.svh"

    localparam logic signed [PROD_W-1:0] EMA_W_S  = PROD_W'(EMA_WEIGHT);
    localparam logic signed [PROD_W-1:0] EMA_RND  = PROD_W'(EMA_ROUND);
    localparam logic signed [PROD_W-1:0] EMA_HI   =
        {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] EMA_LO   =
        {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    logic signed [DATA_W-1:0] ring_mem [HISTORY_DEPTH];
    logic                     ring_we;
    logic [PTR_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] rd_data_reg;

    logic                     enable_reg;
    logic                     enable_next;
    logic                     en_reg;
    logic                     en_next;
    logic signed [DATA_W-1:0] sample_reg;
    logic signed [DATA_W-1:0] sample_next;
    logic                     seed_reg;
    logic                     seed_next;
    logic [PTR_W-1:0]         pos_reg;
    logic [PTR_W-1:0]         pos_next;
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic [DATA_W-1:0]        count_reg;
    logic [DATA_W-1:0]        count_next;
    logic signed [DATA_W-1:0] ema_reg;
    logic signed [DATA_W-1:0] ema_next;
    logic signed [DATA_W-1:0] last_reg;
    logic signed [DATA_W-1:0] last_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [CNT_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         idx_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [DATA_W-1:0] min_reg;
    logic signed [DATA_W-1:0] min_next;
    logic signed [DATA_W-1:0] max_reg;
    logic signed [DATA_W-1:0] max_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     out_busy;
    logic                     emit;
    logic signed [DATA_W-1:0] o_latest_reg;
    logic signed [DATA_W-1:0] o_smoothed_reg;
    logic signed [DATA_W-1:0] o_mean_reg;
    logic signed [DATA_W-1:0] o_min_reg;
    logic signed [DATA_W-1:0] o_max_reg;
    logic [FILLED_W-1:0]      o_filled_reg;
    logic [DATA_W-1:0]        o_total_reg;

    logic signed [DATA_W:0]   ema_diff;
    logic signed [PROD_W-1:0] diff_ext;
    logic signed [PROD_W-1:0] ema_sum;
    logic [CNT_W:0]           idx_inc;

    assign in_ready  = (ctrl.op == OP_ACCEPT);
    assign cfg_ready = 1'b1;
    assign out_busy  = out_valid_reg && !out_ready;
    assign emit      = (ctrl.op == OP_EMIT) && !out_busy;
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;

    assign status.no_input  = !in_valid;
    assign status.empty     = (fill_reg == '0);
    assign status.scan_more = (idx_inc < {1'b0, fill_reg});
    assign status.div_busy  = div_busy;
    assign status.out_busy  = out_busy;

    assign ema_diff = {sample_reg[DATA_W-1], sample_reg} - {ema_reg[DATA_W-1], ema_reg};
    assign diff_ext = PROD_W'(ema_diff);
    assign ema_sum  = PROD_W'(ema_reg) + (prod_reg >>> EMA_SHIFT);

    assign div_start    = (ctrl.op == OP_DIV);
    assign div_dividend = sum_reg;
    assign div_divisor  = fill_reg;

    assign enable_next = cfg_valid ? cfg_data : enable_reg;

    always_comb
    begin
        en_next     = en_reg;
        sample_next = sample_reg;
        seed_next   = seed_reg;
        pos_next    = pos_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        ema_next    = ema_reg;
        last_next   = last_reg;
        prod_next   = prod_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        ring_we     = 1'b0;
        rd_addr     = '0;
        unique case (ctrl.op)
            OP_ACCEPT:
            begin
                if (in_valid)
                begin
                    sample_next = sample;
                    en_next     = enable_reg;
                end
            end
            OP_UPDATE:
            begin
                prod_next = diff_ext * EMA_W_S + EMA_RND;
                seed_next = (count_reg == '0);
                if (en_reg)
                begin
                    ring_we   = 1'b1;
                    last_next = sample_reg;
                    pos_next  = (pos_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
                    if (fill_reg != CNT_W'(HISTORY_DEPTH))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            OP_EMA:
            begin
                if (en_reg)
                begin
                    if (seed_reg)
                    begin
                        ema_next = sample_reg;
                    end
                    else if (ema_sum > EMA_HI)
                    begin
                        ema_next = EMA_HI[DATA_W-1:0];
                    end
                    else if (ema_sum < EMA_LO)
                    begin
                        ema_next = EMA_LO[DATA_W-1:0];
                    end
                    else
                    begin
                        ema_next = ema_sum[DATA_W-1:0];
                    end
                end
            end
            OP_PRIME:
            begin
                idx_next = '0;
                sum_next = '0;
                rd_addr  = '0;
            end
            OP_SCAN:
            begin
                rd_addr  = idx_inc[PTR_W-1:0];
                sum_next = sum_reg + SUM_W'(rd_data_reg);
                idx_next = idx_inc[CNT_W-1:0];
                if (idx_reg == '0)
                begin
                    min_next = rd_data_reg;
                    max_next = rd_data_reg;
                end
                else
                begin
                    if (rd_data_reg < min_reg)
                    begin
                        min_next = rd_data_reg;
                    end
                    if (rd_data_reg > max_reg)
                    begin
                        max_next = rd_data_reg;
                    end
                end
            end
            OP_DIV:
            begin
            end
            OP_EMIT:
            begin
            end
            OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[pos_reg] <= sample_reg;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            pos_reg       <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            ema_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            enable_reg    <= enable_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            ema_reg       <= ema_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        en_reg     <= en_next;
        sample_reg <= sample_next;
        seed_reg   <= seed_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        idx_reg    <= idx_next;
        sum_reg    <= sum_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
    end

    // empty window reports zero statistics
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            o_smoothed_reg <= ema_reg;
            o_filled_reg   <= FILLED_W'(fill_reg);
            o_total_reg    <= count_reg;
            if (fill_reg == '0)
            begin
                o_latest_reg <= '0;
                o_mean_reg   <= '0;
                o_min_reg    <= '0;
                o_max_reg    <= '0;
            end
            else
            begin
                o_latest_reg <= last_reg;
                o_mean_reg   <= div_quotient;
                o_min_reg    <= min_reg;
                o_max_reg    <= max_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign latest      = o_latest_reg;
    assign smoothed    = o_smoothed_reg;
    assign window_mean = o_mean_reg;
    assign window_min  = o_min_reg;
    assign window_max  = o_max_reg;
    assign filled      = o_filled_reg;
    assign total_seen  = o_total_reg;

    `WSM_ASSERT_NEXT(a_disabled_hold, (ctrl.op == OP_UPDATE) && !en_reg, $stable(count_reg) && $stable(fill_reg) && $stable(pos_reg), "disabled beat changed state")
    `WSM_ASSERT_IMPL(a_scan_in_window, ctrl.op == OP_SCAN, idx_reg < fill_reg, "scan index beyond filled window")
    `WSM_ASSERT_NEXT(a_count_saturates, count_reg == COUNT_MAX, count_reg == COUNT_MAX, "sample count wrapped")

endmodule

// ===== rtl/window_stats_monitor.sv =====
// ----------------------------------------------------------------------------
// window_stats_monitor
// sliding window min, max, mean and moving average over signed q16.16 samples
// ----------------------------------------------------------------------------
// channel   signals                              width  direction
// in        in_valid, in_ready, sample           32     sample beat in
// out       out_valid, out_ready, latest ...     32/8   one result beat per sample
// cfg       cfg_valid, cfg_ready, cfg_data       1      sample_enable write
//
// from acceptance, a beat passes through update, moving average, prime, the ring
// scan (one entry a cycle on the single read port), the divider and emit when the
// window holds samples, and from the moving average straight to emit when empty
// the next sample beat is taken once the result is in the output register
// reset is asynchronous, active low; the ring needs no clearing pass
// a stalled result holds the microcode at its last step
// ----------------------------------------------------------------------------
module window_stats_monitor
    import wsm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [DATA_W-1:0]   sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [DATA_W-1:0]   latest,
    output logic signed [DATA_W-1:0]   smoothed,
    output logic signed [DATA_W-1:0]   window_mean,
    output logic signed [DATA_W-1:0]   window_min,
    output logic signed [DATA_W-1:0]   window_max,
    output logic        [FILLED_W-1:0] filled,
    output logic        [DATA_W-1:0]   total_seen,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data
);

    ctrl_t                    ctrl;
    status_t                  status;
    logic                     div_start;
    logic signed [SUM_W-1:0]  div_dividend;
    logic        [CNT_W-1:0]  div_divisor;
    logic                     div_busy;
    logic signed [DATA_W-1:0] div_quotient;

    wsm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    wsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    wsm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .latest       (latest),
        .smoothed     (smoothed),
        .window_mean  (window_mean),
        .window_min   (window_min),
        .window_max   (window_max),
        .filled       (filled),
        .total_seen   (total_seen),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_busy     (div_busy),
        .div_quotient (div_quotient)
    );

endmodule
